// ----- rtl/core/sgct_pkg.sv -----
// ============================================================================
// sgct_pkg
// Shared widths, constants and payload types of the spring torque pipeline.
// ============================================================================
package sgct_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;
    localparam int MAX_STAGES      = 24;
    localparam int N_STG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    localparam int ANGLE_W     = 16;
    localparam int ANGLE_SHIFT = 28 - ANGLE_FRAC_BITS;
    localparam int THETA_RAW_W = ANGLE_W + ANGLE_SHIFT + 3;
    localparam int THETA_W     = (THETA_RAW_W > 34) ? THETA_RAW_W : 34;
    // number of 2*pi steps on either side that the wrap stage checks
    localparam int WRAP_K = ((1 << (ANGLE_W - ANGLE_FRAC_BITS)) * 2) / 6 + 2;

    localparam int CW       = 32;   // CORDIC datapath
    localparam int CS8_W    = 24;
    localparam int STIFF_W  = 16;
    localparam int QCD_W    = 29;
    localparam int P_W      = 30;
    localparam int TWOCD_W  = 40;
    localparam int TC_LO_W  = 20;
    localparam int PP_W     = CS8_W + TC_LO_W + 1;
    localparam int L2_W     = 42;
    localparam int LS_W     = L2_W + 2;
    localparam int ROOT_W   = L2_W / 2;
    localparam int SQ_W     = L2_W + 2;
    localparam int PRE_W    = 20;
    localparam int N_W      = ROOT_W + 2;
    localparam int QUO_BITS = 31;
    localparam int REM_W    = N_W + 24 + 1;
    localparam int DIV_W    = ROOT_W + QUO_BITS + 1;
    localparam int T1_W     = 34;
    localparam int RATIO_W  = 32;
    localparam int F_W      = 34;
    localparam int TORQUE_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam longint Q28_PI          = 64'sd843314857;
    localparam longint Q28_TWO_PI      = 64'sd1686629713;
    localparam longint Q28_HALF_PI     = 64'sd421657428;
    localparam longint Q28_CORDIC_GAIN = 64'sd163008218;
    localparam longint Q28_OFFSET_J2   = 64'sd145044219;
    localparam longint Q28_OFFSET_J3   = 64'sd665952366;
    localparam longint Q48_SUMSQ_J2    = 64'sd638335285371;
    localparam longint Q48_TWOCD_J2    = 64'sd630869865302;
    localparam longint Q48_SUMSQ_J3    = 64'sd429421039220;
    localparam longint Q48_TWOCD_J3    = 64'sd418947355336;
    localparam longint Q40_QCD_J2      = 64'sd308041926;
    localparam longint Q40_QCD_J3      = 64'sd204564138;
    localparam longint Q24_PRELOAD_J2  = -64'sd186227;
    localparam longint Q24_PRELOAD_J3  = -64'sd150995;
    localparam longint RATIO_LIMIT     = 64'sd1073741824;

    typedef enum logic {
        REG_STIFF_J2 = 1'b0,
        REG_STIFF_J3 = 1'b1
    } sgct_reg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] joint2_angle;
        logic signed [ANGLE_W-1:0] joint3_angle;
    } sgct_in_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque_joint2;
        logic signed [TORQUE_W-1:0] torque_joint3;
    } sgct_out_t;

    function automatic logic signed [CW-1:0] atan_at(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = CW'(210828714);
            1:  v = CW'(124459457);
            2:  v = CW'(65760959);
            3:  v = CW'(33381290);
            4:  v = CW'(16755422);
            5:  v = CW'(8385879);
            6:  v = CW'(4193963);
            7:  v = CW'(2097109);
            8:  v = CW'(1048571);
            9:  v = CW'(524287);
            10: v = CW'(262144);
            11: v = CW'(131072);
            12: v = CW'(65536);
            13: v = CW'(32768);
            14: v = CW'(16384);
            15: v = CW'(8192);
            16: v = CW'(4096);
            17: v = CW'(2048);
            18: v = CW'(1024);
            19: v = CW'(512);
            20: v = CW'(256);
            21: v = CW'(128);
            22: v = CW'(64);
            23: v = CW'(32);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/sgct_cordic.sv -----
// ============================================================================
// sgct_cordic
// Angle wrap, quadrant fold and pipelined rotation-mode CORDIC: sin and cos.
// ============================================================================
module sgct_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [sgct_pkg::THETA_W-1:0]  theta,
    output logic                                 out_valid,
    output logic signed [sgct_pkg::CW-1:0]       sn,
    output logic signed [sgct_pkg::CW-1:0]       cs
);
    import sgct_pkg::*;

    logic                 wrap_v_reg;
    logic signed [CW-1:0] wrap_r_reg, wrap_r_next;
    logic signed [CW-1:0] z0_next;
    logic                 flip0_next;

    logic                 v_reg    [0:N_STG];
    logic                 flip_reg [0:N_STG];
    logic signed [CW-1:0] x_reg    [0:N_STG];
    logic signed [CW-1:0] y_reg    [0:N_STG];
    logic signed [CW-1:0] z_reg    [0:N_STG];

    logic                 out_v_reg;
    logic signed [CW-1:0] sn_reg, cs_reg;

    // bring theta into (pi - 2pi, pi]
    always_comb begin
        logic signed [THETA_W-1:0] r;
        r = theta + THETA_W'(longint'(WRAP_K) * Q28_TWO_PI);
        for (int j = -WRAP_K; j < WRAP_K; j++) begin
            if (theta > THETA_W'(Q28_PI + longint'(j) * Q28_TWO_PI)) begin
                r = theta - THETA_W'(longint'(j + 1) * Q28_TWO_PI);
            end
        end
        wrap_r_next = CW'(r);
    end

    // fold into +-pi/2, negate the result later
    always_comb begin
        if (wrap_r_reg > CW'(Q28_HALF_PI)) begin
            z0_next    = wrap_r_reg - CW'(Q28_PI);
            flip0_next = 1'b1;
        end else if (wrap_r_reg < CW'(-Q28_HALF_PI)) begin
            z0_next    = wrap_r_reg + CW'(Q28_PI);
            flip0_next = 1'b1;
        end else begin
            z0_next    = wrap_r_reg;
            flip0_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_v_reg <= 1'b0;
            v_reg[0]   <= 1'b0;
        end else if (en) begin
            wrap_v_reg <= in_valid;
            v_reg[0]   <= wrap_v_reg;
        end
        if (en) begin
            wrap_r_reg  <= wrap_r_next;
            x_reg[0]    <= CW'(Q28_CORDIC_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            flip_reg[0] <= flip0_next;
        end
    end

    for (genvar i = 0; i < N_STG; i++) begin : g_stg
        logic signed [CW-1:0] dx, dy, at;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = atan_at(i);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[N_STG];
        end
        if (en) begin
            sn_reg <= flip_reg[N_STG] ? -y_reg[N_STG] : y_reg[N_STG];
            cs_reg <= flip_reg[N_STG] ? -x_reg[N_STG] : x_reg[N_STG];
        end
    end

    assign out_valid = out_v_reg;
    assign sn        = sn_reg;
    assign cs        = cs_reg;

endmodule

// ----- rtl/core/sgct_sqrt.sv -----
// ============================================================================
// sgct_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module sgct_sqrt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [sgct_pkg::L2_W-1:0]           l2,
    input  logic signed [sgct_pkg::T1_W-1:0]    t1_in,
    output logic                                out_valid,
    output logic [sgct_pkg::ROOT_W-1:0]         root,
    output logic signed [sgct_pkg::T1_W-1:0]    t1_out
);
    import sgct_pkg::*;

    logic                    v_reg    [0:ROOT_W];
    logic [L2_W-1:0]         rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]       root_reg [0:ROOT_W];
    logic signed [T1_W-1:0]  t1_reg   [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0]  <= l2;
            root_reg[0] <= '0;
            t1_reg[0]   <= t1_in;
        end
    end

    // rem holds v - root^2; setting bit b adds 2*root*2^b + 4^b to root^2
    for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
        localparam int B = ROOT_W - 1 - i;
        logic [SQ_W-1:0] trial;
        logic            take;
        assign trial = (SQ_W'(root_reg[i]) << (B + 1)) + (SQ_W'(1) << (2 * B));
        assign take  = SQ_W'(rem_reg[i]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                t1_reg[i+1] <= t1_reg[i];
                if (take) begin
                    rem_reg[i+1]  <= L2_W'(SQ_W'(rem_reg[i]) - trial);
                    root_reg[i+1] <= root_reg[i] | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i];
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign t1_out    = t1_reg[ROOT_W];

endmodule

// ----- rtl/core/sgct_div.sv -----
// ============================================================================
// sgct_div
// Ratio (preload + L) / L in Q24: restoring divider, one quotient bit per
// stage, truncating toward zero and clamped to +-64.
// ============================================================================
module sgct_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [sgct_pkg::ROOT_W-1:0]          root,
    input  logic signed [sgct_pkg::PRE_W-1:0]    preload,
    input  logic signed [sgct_pkg::T1_W-1:0]     t1_in,
    output logic                                 out_valid,
    output logic signed [sgct_pkg::RATIO_W-1:0]  ratio,
    output logic signed [sgct_pkg::T1_W-1:0]     t1_out
);
    import sgct_pkg::*;

    logic                    v_reg   [0:QUO_BITS];
    logic [REM_W-1:0]        rem_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0]     q_reg   [0:QUO_BITS];
    logic [ROOT_W-1:0]       len_reg [0:QUO_BITS];
    logic                    neg_reg [0:QUO_BITS];
    logic                    ovf_reg [0:QUO_BITS];
    logic signed [T1_W-1:0]  t1_reg  [0:QUO_BITS];

    logic [ROOT_W-1:0]       len;
    logic signed [N_W-1:0]   num;
    logic [N_W-1:0]          mag;
    logic                    ovf;

    logic                    out_v_reg;
    logic signed [RATIO_W-1:0] ratio_reg;
    logic signed [T1_W-1:0]  t1_out_reg;
    logic [RATIO_W-1:0]      qmag;

    assign len = (root == '0) ? ROOT_W'(1) : root;
    assign num = $signed({2'b00, len}) + N_W'(preload);
    assign mag = num[N_W-1] ? N_W'(-num) : N_W'(num);
    // quotient would reach 2^31 exactly when |num| >= len * 128
    assign ovf = (N_W + 8)'(mag) >= ((N_W + 8)'(len) << 7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0] <= REM_W'(mag) << 24;
            q_reg[0]   <= '0;
            len_reg[0] <= len;
            neg_reg[0] <= num[N_W-1];
            ovf_reg[0] <= ovf;
            t1_reg[0]  <= t1_in;
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++) begin : g_bit
        localparam int B = QUO_BITS - 1 - i;
        logic [DIV_W-1:0] sub;
        logic             take;
        assign sub  = DIV_W'(len_reg[i]) << B;
        assign take = DIV_W'(rem_reg[i]) >= sub;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                len_reg[i+1] <= len_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                t1_reg[i+1]  <= t1_reg[i];
                if (take) begin
                    rem_reg[i+1] <= REM_W'(DIV_W'(rem_reg[i]) - sub);
                    q_reg[i+1]   <= q_reg[i] | (QUO_BITS'(1) << B);
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
            end
        end
    end

    always_comb begin
        if (ovf_reg[QUO_BITS] || (RATIO_W'(q_reg[QUO_BITS]) > RATIO_W'(RATIO_LIMIT))) begin
            qmag = RATIO_W'(RATIO_LIMIT);
        end else begin
            qmag = RATIO_W'(q_reg[QUO_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[QUO_BITS];
        end
        if (en) begin
            ratio_reg  <= neg_reg[QUO_BITS] ? -$signed(qmag) : $signed(qmag);
            t1_out_reg <= t1_reg[QUO_BITS];
        end
    end

    assign out_valid = out_v_reg;
    assign ratio     = ratio_reg;
    assign t1_out    = t1_out_reg;

endmodule

// ----- rtl/core/sgct_lane.sv -----
// ============================================================================
// sgct_lane
// One spring: sin/cos, cable length, ratio and spring term in Q16.16.
// ============================================================================
module sgct_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [sgct_pkg::THETA_W-1:0]  theta,
    input  logic [sgct_pkg::P_W-1:0]             p,
    input  logic [sgct_pkg::L2_W-1:0]            sumsq,
    input  logic [sgct_pkg::TWOCD_W-1:0]         twocd,
    input  logic signed [sgct_pkg::PRE_W-1:0]    preload,
    output logic                                 out_valid,
    output logic signed [sgct_pkg::F_W-1:0]      f
);
    import sgct_pkg::*;

    localparam int PR1_W   = P_W + CW + 1;
    localparam int PR2_W   = T1_W + RATIO_W;

    logic                    cv;
    logic signed [CW-1:0]    sn, cs;

    logic signed [CS8_W-1:0] cs8;
    logic signed [PP_W-1:0]  pp_a, pp_blo, pp_bhi;
    logic signed [PR1_W-1:0] pr1;
    logic                    mul_v_reg;
    logic signed [PP_W-1:0]  pp_lo_reg, pp_hi_reg;
    logic signed [T1_W-1:0]  t1_reg;

    logic signed [PP_W-1:0]  acc;
    logic signed [LS_W-1:0]  l2s;
    logic                    l2_v_reg;
    logic [L2_W-1:0]         l2_reg;
    logic signed [T1_W-1:0]  t1_l2_reg;

    logic                    sq_v;
    logic [ROOT_W-1:0]       root;
    logic signed [T1_W-1:0]  t1_sq;

    logic                    dv_v;
    logic signed [RATIO_W-1:0] ratio;
    logic signed [T1_W-1:0]  t1_dv;

    logic signed [PR2_W-1:0] pr2;
    logic                    f_v_reg;
    logic signed [F_W-1:0]   f_reg;

    sgct_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .theta     (theta),
        .out_valid (cv),
        .sn        (sn),
        .cs        (cs)
    );

    // 2cd * cos split in two partial products; t1 = p * sin
    assign cs8    = CS8_W'(cs >>> 8);
    assign pp_a   = PP_W'(cs8);
    assign pp_blo = PP_W'($signed({1'b0, twocd[TC_LO_W-1:0]}));
    assign pp_bhi = PP_W'($signed({1'b0, twocd[TWOCD_W-1:TC_LO_W]}));
    assign pr1    = PR1_W'($signed({1'b0, p})) * PR1_W'(sn);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else if (en) begin
            mul_v_reg <= cv;
        end
        if (en) begin
            pp_lo_reg <= pp_a * pp_blo;
            pp_hi_reg <= pp_a * pp_bhi;
            t1_reg    <= T1_W'(pr1 >>> 28);
        end
    end

    assign acc = pp_hi_reg + (pp_lo_reg >>> TC_LO_W);
    assign l2s = LS_W'($signed({1'b0, sumsq})) - LS_W'(acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l2_v_reg <= 1'b0;
        end else if (en) begin
            l2_v_reg <= mul_v_reg;
        end
        if (en) begin
            l2_reg    <= (l2s < 0) ? '0 : L2_W'(l2s);
            t1_l2_reg <= t1_reg;
        end
    end

    sgct_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l2_v_reg),
        .l2        (l2_reg),
        .t1_in     (t1_l2_reg),
        .out_valid (sq_v),
        .root      (root),
        .t1_out    (t1_sq)
    );

    sgct_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_v),
        .root      (root),
        .preload   (preload),
        .t1_in     (t1_sq),
        .out_valid (dv_v),
        .ratio     (ratio),
        .t1_out    (t1_dv)
    );

    // >>24 then >>8 is one arithmetic shift by 32
    assign pr2 = PR2_W'(t1_dv) * PR2_W'(ratio);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (en) begin
            f_v_reg <= dv_v;
        end
        if (en) begin
            f_reg <= F_W'(pr2 >>> 32);
        end
    end

    assign out_valid = f_v_reg;
    assign f         = f_reg;

endmodule

// ----- rtl/core/spring_gravity_comp_torque_top.sv -----
// ============================================================================
// spring_gravity_comp_torque_top
// Spring gravity compensation torques for joints 2 and 3.
// ============================================================================
// Input words carry the joint 2 and joint 3 angles (Q2.13 rad) on s_valid /
// s_ready; result words carry both torques (Q16.16 N*m, saturated) on
// m_valid / m_ready. Stiffness registers sit on the APB port at 0x0 (joint 2)
// and 0x4 (joint 3), 16 bits each, and are read back on prdata.
// Throughput is one word per cycle while the output does not stall. The
// pipeline runs through the CORDIC stages, the 21-stage square root and
// the 31-stage ratio divider; both springs run in parallel lanes.
// When m_ready is low the output register holds its word and a one-word skid
// register catches the next; once that is full s_ready drops and the whole
// pipeline freezes, nothing is lost or repeated.
// Reset clears all valid bits and both stiffness registers (zero torque).
// The torque scale terms are registered from the stiffness registers, so the
// user writes registers only while the pipeline is empty (not enforced).
// ============================================================================
module spring_gravity_comp_torque_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sgct_pkg::sgct_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sgct_pkg::sgct_out_t                   m_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sgct_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [sgct_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [sgct_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import sgct_pkg::*;

    localparam int KP_W = STIFF_W + QCD_W;
    localparam int S_W  = F_W + 2;

    logic [STIFF_W-1:0]      stiff2_reg, stiff3_reg;
    logic [P_W-1:0]          p2_reg, p3_reg;
    logic                    wr_en;
    sgct_reg_t               reg_sel;

    logic                    en;
    logic signed [THETA_W-1:0] q2, q3;
    logic                    in_v_reg;
    logic signed [THETA_W-1:0] th2_reg, th3_reg;

    logic                    v2, v3;
    logic signed [F_W-1:0]   f2, f3;
    logic signed [S_W-1:0]   s2, s3;
    logic signed [TORQUE_W-1:0] tau2, tau3;

    logic                    fin_v_reg;
    sgct_out_t               fin_reg;
    logic                    skid_full_reg;
    sgct_out_t               skid_reg;
    logic                    m_valid_reg;
    sgct_out_t               m_data_reg;
    logic                    out_load;

    // ---- configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = sgct_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff2_reg <= '0;
            stiff3_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_STIFF_J2: stiff2_reg <= pwdata[STIFF_W-1:0];
                REG_STIFF_J3: stiff3_reg <= pwdata[STIFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_STIFF_J2: prdata = CFG_DATA_W'(stiff2_reg);
            REG_STIFF_J3: prdata = CFG_DATA_W'(stiff3_reg);
            default:      prdata = '0;
        endcase
    end

    // k * c*d/4, Q24 N*m
    always_ff @(posedge aclk) begin
        p2_reg <= P_W'((KP_W'(stiff2_reg) * KP_W'(Q40_QCD_J2)) >> 16);
        p3_reg <= P_W'((KP_W'(stiff3_reg) * KP_W'(Q40_QCD_J3)) >> 16);
    end

    // ---- input stage
    assign en      = ~skid_full_reg;
    assign s_ready = en;

    assign q2 = THETA_W'(s_data.joint2_angle) <<< ANGLE_SHIFT;
    assign q3 = THETA_W'(s_data.joint3_angle) <<< ANGLE_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_valid;
        end
        if (en) begin
            th2_reg <= q2 + THETA_W'(Q28_OFFSET_J2);
            th3_reg <= q2 + q3 + THETA_W'(Q28_OFFSET_J3);
        end
    end

    sgct_lane u_lane_j2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .theta     (th2_reg),
        .p         (p2_reg),
        .sumsq     (L2_W'(Q48_SUMSQ_J2)),
        .twocd     (TWOCD_W'(Q48_TWOCD_J2)),
        .preload   (PRE_W'(Q24_PRELOAD_J2)),
        .out_valid (v2),
        .f         (f2)
    );

    sgct_lane u_lane_j3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .theta     (th3_reg),
        .p         (p3_reg),
        .sumsq     (L2_W'(Q48_SUMSQ_J3)),
        .twocd     (TWOCD_W'(Q48_TWOCD_J3)),
        .preload   (PRE_W'(Q24_PRELOAD_J3)),
        .out_valid (v3),
        .f         (f3)
    );

    // ---- combine and saturate
    assign s2 = -(S_W'(f2) + S_W'(f3));
    assign s3 = -S_W'(f3);

    always_comb begin
        if (s2 > S_W'(64'sd2147483647)) begin
            tau2 = TORQUE_W'(64'sd2147483647);
        end else if (s2 < S_W'(-64'sd2147483648)) begin
            tau2 = TORQUE_W'(-64'sd2147483648);
        end else begin
            tau2 = TORQUE_W'(s2);
        end
        if (s3 > S_W'(64'sd2147483647)) begin
            tau3 = TORQUE_W'(64'sd2147483647);
        end else if (s3 < S_W'(-64'sd2147483648)) begin
            tau3 = TORQUE_W'(-64'sd2147483648);
        end else begin
            tau3 = TORQUE_W'(s3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= v2 & v3;
        end
        if (en) begin
            fin_reg.torque_joint2 <= tau2;
            fin_reg.torque_joint3 <= tau3;
        end
    end

    // ---- output register plus one-word skid
    assign out_load = ~m_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (out_load) begin
                m_valid_reg   <= 1'b1;
                m_data_reg    <= skid_reg;
                skid_full_reg <= 1'b0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= fin_v_reg;
                m_data_reg  <= fin_reg;
            end else if (fin_v_reg) begin
                skid_full_reg <= 1'b1;
                skid_reg      <= fin_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- verif/spring_gravity_comp_torque_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// spring_gravity_comp_torque_top_tb
// Drives angle pairs through the spring torque pipeline and checks every
// torque word against a bit-true fixed-point predictor or known table value,
// across stiffness settings, with random sender bursts and receiver stalls.
// ============================================================================
module spring_gravity_comp_torque_top_tb;
    import sgct_pkg::*;

    localparam int N_RANDOM = 1450;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sgct_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sgct_out_t m_data;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic      pready;

    longint    k_j2, k_j3;
    sgct_out_t torque_q[$];
    int        n_err;
    bit        stall_on;

    spring_gravity_comp_torque_top DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint spring_force(longint theta, longint sumsq, longint twocd,
                                            longint qcd, longint preload, longint k);
        longint r, x, y, z, dx, dy, l2, len, ratio, p, t;
        bit     flip;
        r = theta % Q28_TWO_PI;
        if (r < 0) r += Q28_TWO_PI;
        if (r > Q28_PI) r -= Q28_TWO_PI;
        flip = 1'b0;
        if (r > Q28_HALF_PI) begin
            r -= Q28_PI; flip = 1'b1;
        end else if (r < -Q28_HALF_PI) begin
            r += Q28_PI; flip = 1'b1;
        end
        x = Q28_CORDIC_GAIN; y = 0; z = r;
        for (int i = 0; i < N_STG; i++) begin
            dx = shr(x, i); dy = shr(y, i);
            if (z >= 0) begin
                x -= dy; y += dx; z -= longint'(atan_at(i));
            end else begin
                x += dy; y -= dx; z += longint'(atan_at(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        l2 = sumsq - shr(twocd * shr(x, 8), 20);
        if (l2 < 0) l2 = 0;
        len = int_sqrt(l2);
        if (len == 0) len = 1;
        ratio = ((preload + len) * 64'sd16777216) / len;
        if (ratio > RATIO_LIMIT) ratio = RATIO_LIMIT;
        if (ratio < -RATIO_LIMIT) ratio = -RATIO_LIMIT;
        p = shr(k * qcd, 16);
        t = shr(p * y, 28);
        t = shr(t * ratio, 24);
        return shr(t, 8);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic sgct_out_t comp_torque(sgct_in_t w);
        longint    q2, q3, f2, f3;
        sgct_out_t o;
        q2 = longint'(w.joint2_angle) <<< ANGLE_SHIFT;
        q3 = longint'(w.joint3_angle) <<< ANGLE_SHIFT;
        f3 = spring_force(q2 + q3 + Q28_OFFSET_J3, Q48_SUMSQ_J3, Q48_TWOCD_J3,
                          Q40_QCD_J3, Q24_PRELOAD_J3, k_j3);
        f2 = spring_force(q2 + Q28_OFFSET_J2, Q48_SUMSQ_J2, Q48_TWOCD_J2,
                          Q40_QCD_J2, Q24_PRELOAD_J2, k_j2);
        o.torque_joint2 = sat32(-(f2 + f3));
        o.torque_joint3 = sat32(-f3);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    // receiver: checks each accepted word; stall pattern, with stretches of no stalls
    always @(posedge aclk) begin
        sgct_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (torque_q.size() == 0) begin
                report_mismatch("unexpected word", m_data.torque_joint2, 0);
            end else begin
                want = torque_q.pop_front();
                if (m_data.torque_joint2 !== want.torque_joint2)
                    report_mismatch("torque_joint2", m_data.torque_joint2,
                                    want.torque_joint2);
                if (m_data.torque_joint3 !== want.torque_joint3)
                    report_mismatch("torque_joint3", m_data.torque_joint3,
                                    want.torque_joint3);
            end
        end
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
        m_ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    task automatic reg_write(sgct_reg_t idx, int unsigned val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(int'(idx) * 4); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_STIFF_J2) k_j2 = longint'(val & 32'hFFFF);
        else k_j3 = longint'(val & 32'hFFFF);
    endtask

    // word goes out; valid holds until accepted
    task automatic send_angles(sgct_in_t w, bit have_want, sgct_out_t want);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        torque_q.push_back(have_want ? want : comp_torque(w));
    endtask

    task automatic drain();
        while (torque_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic random_burst(int n, bit wide);
        sgct_in_t w;
        int       burst;
        int       gap;
        burst = 0;
        @(posedge aclk);
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 40);
            end
            burst--;
            if (wide) begin
                w.joint2_angle = 16'($urandom);
                w.joint3_angle = 16'($urandom);
            end else begin
                w.joint2_angle = 16'($urandom_range(0, 51472) - 25736);
                w.joint3_angle = 16'($urandom_range(0, 51472) - 25736);
            end
            send_angles(w, 1'b0, '0);
        end
        s_valid <= 1'b0;
    endtask

    typedef struct {
        logic signed [15:0] a2, a3;
        bit                 known;
        logic signed [31:0] t2, t3;
    } angle_row_t;

    angle_row_t dir_tab[] = '{
        '{16'sd0, 16'sd0, 1, 32'sd0, 32'sd0},
        '{16'sd25736, 16'sd25736, 1, 32'sd0, 32'sd0},
        '{-16'sd25736, -16'sd25736, 1, 32'sd0, 32'sd0},
        '{16'sh7FFF, 16'sh8000, 1, 32'sd0, 32'sd0},
        '{16'sh8000, 16'sh7FFF, 1, 32'sd0, 32'sd0},
        '{16'shFFFF, 16'shFFFF, 1, 32'sd0, 32'sd0}
    };

    angle_row_t load_tab[] = '{
        '{16'sd0, 16'sd0, 0, 0, 0},
        '{16'sd25736, 16'sd25736, 0, 0, 0},
        '{-16'sd25736, -16'sd25736, 0, 0, 0},
        '{16'sh7FFF, 16'sh7FFF, 0, 0, 0},
        '{16'sh8000, 16'sh8000, 0, 0, 0},
        '{16'sd12868, 16'sd0, 0, 0, 0},      // near +pi/2 on joint 2
        '{-16'sd12868, 16'sd5000, 0, 0, 0},
        '{-16'sd1188, 16'sd0, 0, 0, 0},      // joint-2 spring near zero length
        '{16'sd0, -16'sd5453, 0, 0, 0},      // joint-3 spring near zero length
        '{16'sd1000, -16'sd6453, 0, 0, 0},
        '{16'sd25736, -16'sd25736, 0, 0, 0},
        '{16'sh5555, 16'shAAAA, 0, 0, 0},
        '{16'shAAAA, 16'sh5555, 0, 0, 0}
    };

    task automatic run_table(angle_row_t tab[]);
        sgct_in_t  w;
        sgct_out_t want;
        foreach (tab[i]) begin
            w.joint2_angle = tab[i].a2;
            w.joint3_angle = tab[i].a3;
            want.torque_joint2 = tab[i].t2;
            want.torque_joint3 = tab[i].t3;
            send_angles(w, tab[i].known, want);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        k_j2 = 0; k_j3 = 0; n_err = 0; stall_on = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // stiffness zero after reset: every torque is zero
        run_table(dir_tab);
        drain();
        reg_write(REG_STIFF_J2, 32'hFFFF);
        reg_write(REG_STIFF_J3, 32'hFFFF);
        run_table(load_tab);
        drain();
        reg_write(REG_STIFF_J2, 32'h0001);
        reg_write(REG_STIFF_J3, 32'hFFFF);
        run_table(load_tab);
        random_burst(N_RANDOM / 4, 1'b1);
        drain();
        reg_write(REG_STIFF_J2, 32'hFFFF);
        reg_write(REG_STIFF_J3, 32'h0000);
        random_burst(N_RANDOM / 4, 1'b0);
        drain();
        reg_write(REG_STIFF_J2, $urandom);
        reg_write(REG_STIFF_J3, $urandom);
        random_burst(N_RANDOM / 4, 1'b0);
        drain();
        reg_write(REG_STIFF_J2, 32'hFFFF);
        reg_write(REG_STIFF_J3, 32'hFFFF);
        random_burst(N_RANDOM / 4, 1'b1);
        drain();
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
